### hdl/flow_chain_bilinear_compose_assert.svh
// assertion macros for the flow chain compose block
// expects signals clk and rst_n in the module that uses them
`ifndef FLOW_CHAIN_BILINEAR_COMPOSE_ASSERT_SVH
`define FLOW_CHAIN_BILINEAR_COMPOSE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FCBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FCBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCBC_ASSERT_NOW(lbl, ante, cons, msg)
`define FCBC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/fcbc_pkg.sv
// shared types and constants of the flow chain compose block
// no dependencies
`default_nettype none
package fcbc_pkg;
    localparam int FLOW_W = 20;
    localparam int CFG_IW = 2;
    localparam int ENTRY_W = 2 * FLOW_W;

    localparam logic [CFG_IW-1:0] CFG_REGION_Y = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_REGION_X = 2'd1;

    localparam logic signed [FLOW_W+1:0] FLOW_MAX = 22'sd524287;
    localparam logic signed [FLOW_W+1:0] FLOW_MIN = -22'sd524288;

    typedef struct packed {
        logic                     action;
        logic [9:0]               map_row;
        logic [9:0]               map_col;
        logic signed [FLOW_W-1:0] load_flow_x;
        logic signed [FLOW_W-1:0] load_flow_y;
        logic [11:0]              pixel_y;
        logic [11:0]              pixel_x;
        logic signed [FLOW_W-1:0] acc_flow_x;
        logic signed [FLOW_W-1:0] acc_flow_y;
        logic                     acc_valid;
    } req_t;

    typedef struct packed {
        logic [11:0]              out_pixel_y;
        logic [11:0]              out_pixel_x;
        logic signed [FLOW_W-1:0] out_flow_x;
        logic signed [FLOW_W-1:0] out_flow_y;
        logic                     out_valid;
    } rsp_t;
endpackage
`default_nettype wire

### hdl/flow_chain_bilinear_compose.sv
// top level: five stage bilinear flow compose pipeline with output skid
// uses fcbc_pkg, fcbc_flow_bank and flow_chain_bilinear_compose_assert.svh
//
//  channel  signals                         direction
//  req      req_valid req_stall req         in, load or compose request
//  rsp      rsp_valid rsp_stall rsp         out, one per compose request
//  cfg      cfg_valid cfg_ready idx data    in, region offset writes
//
// one request per cycle while req_stall is low; a compose result passes through every stage
// stages: target position, bank read, two multiply stages and the round/saturate stage
// four map banks by row and column parity give all neighbors in one read
// reset clears valid bits and offsets only; map contents undefined until loaded
// a stalled result moves to a skid register, req_stall rises only while it is full
`default_nettype none
`include "flow_chain_bilinear_compose_assert.svh"
module flow_chain_bilinear_compose #(
    parameter int MAP_RES   = 1024,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire fcbc_pkg::req_t              req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output fcbc_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [fcbc_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [11:0]                 cfg_data
);
    localparam int F   = FRAC_BITS;
    localparam int FW  = fcbc_pkg::FLOW_W;
    localparam int EW  = fcbc_pkg::ENTRY_W;
    localparam int TW  = (((14 + F) > FW) ? (14 + F) : FW) + 1;
    localparam int RW  = $clog2(MAP_RES);
    localparam int HW  = (MAP_RES > 2) ? ($clog2(MAP_RES) - 1) : 1;
    localparam int AW  = 2 * HW;
    localparam int HX  = FW + F + 1;
    localparam int VX  = FW + 2 * F + 1;
    localparam int RX  = VX - 2 * F;
    localparam logic [F:0] ONE = (F + 1)'(1) << F;
    localparam logic signed [TW-1:0] LIM = TW'((MAP_RES - 1) * (2 ** F));
    localparam logic signed [VX-1:0] HALF = VX'(1) <<< (2 * F - 1);

    logic signed [11:0] off_y_reg, off_x_reg;
    logic en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_y_reg <= '0;
            off_x_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fcbc_pkg::CFG_REGION_Y: off_y_reg <= cfg_data;
                fcbc_pkg::CFG_REGION_X: off_x_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: target position
    logic signed [13:0] dy, dx;
    logic signed [TW-1:0] ty_next, tx_next, ty_reg, tx_reg;
    logic s1_v_reg;
    fcbc_pkg::req_t s1_reg;

    always_comb
    begin
        dy = $signed({2'b00, req.pixel_y}) - 14'(off_y_reg);
        dx = $signed({2'b00, req.pixel_x}) - 14'(off_x_reg);
        ty_next = (TW'(dy) <<< F) - TW'(req.acc_flow_y);
        tx_next = (TW'(dx) <<< F) - TW'(req.acc_flow_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= req;
            ty_reg <= ty_next;
            tx_reg <= tx_next;
        end
    end

    // stage 2: bounds, cell, bank access
    logic [RW-1:0] r1, c1;
    logic inb1, load_ok;
    logic [EW-1:0] rdata [4];

    always_comb
    begin
        r1 = ty_reg[F+RW-1:F];
        c1 = tx_reg[F+RW-1:F];
        inb1 = (ty_reg >= 0) && (tx_reg >= 0) && (ty_reg <= LIM) && (tx_reg <= LIM);
        load_ok = s1_v_reg && !s1_reg.action
            && ({3'b000, s1_reg.map_row} < 13'(MAP_RES))
            && ({3'b000, s1_reg.map_col} < 13'(MAP_RES));
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PR = b[1];
        localparam logic PC = b[0];
        logic [HW-1:0] rh, ch;
        logic we;
        always_comb
        begin
            rh = HW'(r1 >> 1) + HW'(r1[0] & ~PR);
            ch = HW'(c1 >> 1) + HW'(c1[0] & ~PC);
            we = en && load_ok && (s1_reg.map_row[0] == PR) && (s1_reg.map_col[0] == PC);
        end
        fcbc_flow_bank #(.AW(AW)) u_bank (
            .clk   (clk),
            .en    (en),
            .we    (we),
            .waddr ({HW'(s1_reg.map_row >> 1), HW'(s1_reg.map_col >> 1)}),
            .wdata ({s1_reg.load_flow_y, s1_reg.load_flow_x}),
            .raddr ({rh, ch}),
            .rdata (rdata[b])
        );
    end

    logic s2_v_reg;
    logic s2_inb_reg, s2_r0_reg, s2_c0_reg;
    logic [F-1:0] s2_fy_reg, s2_fx_reg;
    fcbc_pkg::req_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg && s1_reg.action;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s1_reg;
            s2_inb_reg <= inb1;
            s2_r0_reg <= r1[0];
            s2_c0_reg <= c1[0];
            s2_fy_reg <= ty_reg[F-1:0];
            s2_fx_reg <= tx_reg[F-1:0];
        end
    end

    // stage 3: horizontal blend per neighbor row
    logic signed [FW-1:0] smp [2][2][2];
    logic signed [HX-1:0] h_next [2][2];
    logic signed [HX-1:0] h_reg [2][2];
    logic [F:0] wx0, wx1;

    always_comb
    begin
        wx1 = {1'b0, s2_fx_reg};
        wx0 = ONE - wx1;
        for (int dr = 0; dr < 2; dr++)
        begin
            for (int dc = 0; dc < 2; dc++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    smp[dr][dc][k] = rdata[{1'(dr) ^ s2_r0_reg, 1'(dc) ^ s2_c0_reg}][k*FW +: FW];
                    if ((dr == 1 && s2_fy_reg == '0) || (dc == 1 && s2_fx_reg == '0))
                    begin
                        smp[dr][dc][k] = '0;
                    end
                end
            end
        end
        for (int dr = 0; dr < 2; dr++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                h_next[dr][k] = HX'(smp[dr][0][k]) * HX'($signed({1'b0, wx0}))
                    + HX'(smp[dr][1][k]) * HX'($signed({1'b0, wx1}));
            end
        end
    end

    logic s3_v_reg, s3_inb_reg;
    logic [F-1:0] s3_fy_reg;
    fcbc_pkg::req_t s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s2_reg;
            s3_inb_reg <= s2_inb_reg;
            s3_fy_reg <= s2_fy_reg;
            h_reg <= h_next;
        end
    end

    // stage 4: vertical blend
    logic [F:0] wy0, wy1;
    logic signed [VX-1:0] v_next [2];
    logic signed [VX-1:0] v_reg [2];

    always_comb
    begin
        wy1 = {1'b0, s3_fy_reg};
        wy0 = ONE - wy1;
        for (int k = 0; k < 2; k++)
        begin
            v_next[k] = VX'(h_reg[0][k]) * VX'($signed({1'b0, wy0}))
                + VX'(h_reg[1][k]) * VX'($signed({1'b0, wy1}));
        end
    end

    logic s4_v_reg, s4_inb_reg;
    fcbc_pkg::req_t s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg <= s3_reg;
            s4_inb_reg <= s3_inb_reg;
            v_reg <= v_next;
        end
    end

    // stage 5: round, accumulate, saturate
    logic signed [VX-1:0] vr [2];
    logic signed [FW+1:0] acc_sum [2];
    logic signed [FW-1:0] sat [2];
    fcbc_pkg::rsp_t rsp_next, s5_reg, skid_reg;
    logic s5_v_reg, skid_v_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            vr[k] = (v_reg[k] + HALF) >>> (2 * F);
            acc_sum[k] = (FW + 2)'($signed(vr[k][RX-1:0]))
                + (FW + 2)'((k == 0) ? s4_reg.acc_flow_x : s4_reg.acc_flow_y);
            if (acc_sum[k] > fcbc_pkg::FLOW_MAX)
            begin
                sat[k] = fcbc_pkg::FLOW_MAX[FW-1:0];
            end
            else if (acc_sum[k] < fcbc_pkg::FLOW_MIN)
            begin
                sat[k] = fcbc_pkg::FLOW_MIN[FW-1:0];
            end
            else
            begin
                sat[k] = acc_sum[k][FW-1:0];
            end
        end
        rsp_next.out_pixel_y = s4_reg.pixel_y;
        rsp_next.out_pixel_x = s4_reg.pixel_x;
        if (!s4_reg.acc_valid)
        begin
            rsp_next.out_flow_x = s4_reg.acc_flow_x;
            rsp_next.out_flow_y = s4_reg.acc_flow_y;
            rsp_next.out_valid = 1'b0;
        end
        else if (!s4_inb_reg)
        begin
            rsp_next.out_flow_x = '0;
            rsp_next.out_flow_y = '0;
            rsp_next.out_valid = 1'b0;
        end
        else
        begin
            rsp_next.out_flow_x = sat[0];
            rsp_next.out_flow_y = sat[1];
            rsp_next.out_valid = 1'b1;
        end
    end

    assign en = !skid_v_reg;
    assign req_stall = skid_v_reg;
    assign rsp_valid = skid_v_reg || s5_v_reg;
    assign rsp = skid_v_reg ? skid_reg : s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (!rsp_stall)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else
        begin
            s5_v_reg <= s4_v_reg;
            skid_v_reg <= s5_v_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= rsp_next;
            if (s5_v_reg && rsp_stall)
            begin
                skid_reg <= s5_reg;
            end
        end
    end

    `FCBC_ASSERT_NEXT(a_skid_hold, skid_v_reg && rsp_stall, skid_v_reg && $stable(skid_reg), "skid lost a stalled result")
    `FCBC_ASSERT_NEXT(a_skid_catch, s5_v_reg && !skid_v_reg && rsp_stall, skid_v_reg, "stalled result not caught")
    `FCBC_ASSERT_NEXT(a_freeze, !en, $stable(s5_v_reg) && $stable(s4_v_reg), "pipeline moved while frozen")
endmodule
`default_nettype wire

### hdl/fcbc_flow_bank.sv
// one bank of the flow map, one write and one registered read port
// uses fcbc_pkg for the entry width
`default_nettype none
module fcbc_flow_bank #(
    parameter int AW = 18
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic                         we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic [fcbc_pkg::ENTRY_W-1:0] wdata,
    input  wire logic [AW-1:0]                raddr,
    output logic      [fcbc_pkg::ENTRY_W-1:0] rdata
);
    logic [fcbc_pkg::ENTRY_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (en)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### tb/sv/flow_chain_bilinear_compose_chk.sv
// checker for the flow chain compose block: watches request, result and config channels
// predicts each compose result from its own copy of the map and offsets; uses fcbc_pkg
`default_nettype none
module flow_chain_bilinear_compose_chk
    import fcbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire req_t              req,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire rsp_t              rsp,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [11:0]       cfg_data,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RES  = 1024;
    localparam longint ONE = 256;

    logic [ENTRY_W-1:0] flow_store [int];
    longint             off_y, off_x;
    rsp_t               composed_q [$];

    function automatic longint map_sample(longint r, longint c, bit comp);
        logic [ENTRY_W-1:0] e;
        logic signed [FLOW_W-1:0] v;
        if (r >= RES || c >= RES || !flow_store.exists(int'(r * RES + c)))
            return 0;
        e = flow_store[int'(r * RES + c)];
        v = comp ? e[2*FLOW_W-1:FLOW_W] : e[FLOW_W-1:0];
        return longint'(v);
    endfunction

    function automatic longint interp(longint r, longint c, longint fy, longint fx, bit comp);
        longint s;
        s = map_sample(r, c, comp) * (ONE - fy) * (ONE - fx)
          + map_sample(r, c + 1, comp) * (ONE - fy) * fx
          + map_sample(r + 1, c, comp) * fy * (ONE - fx)
          + map_sample(r + 1, c + 1, comp) * fy * fx;
        return (s + 32768) >>> 16;
    endfunction

    function automatic longint clip20(longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic rsp_t compose_pixel(req_t r);
        rsp_t   o;
        longint ax, ay, ty, tx, nx, ny;
        ax = longint'(r.acc_flow_x);
        ay = longint'(r.acc_flow_y);
        nx = ax;
        ny = ay;
        o.out_valid = r.acc_valid;
        if (r.acc_valid)
        begin
            ty = longint'(r.pixel_y) * ONE - off_y * ONE - ay;
            tx = longint'(r.pixel_x) * ONE - off_x * ONE - ax;
            if (ty < 0 || tx < 0 || ty > (RES - 1) * ONE || tx > (RES - 1) * ONE)
            begin
                o.out_valid = 1'b0;
                nx = 0;
                ny = 0;
            end
            else
            begin
                nx = clip20(ax + interp(ty >>> 8, tx >>> 8, ty & 255, tx & 255, 1'b0));
                ny = clip20(ay + interp(ty >>> 8, tx >>> 8, ty & 255, tx & 255, 1'b1));
            end
        end
        o.out_pixel_y = r.pixel_y;
        o.out_pixel_x = r.pixel_x;
        o.out_flow_x  = nx[FLOW_W-1:0];
        o.out_flow_y  = ny[FLOW_W-1:0];
        return o;
    endfunction

    assign pending = composed_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            errors = 0;
            off_y  = 0;
            off_x  = 0;
            composed_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_REGION_Y)
                    off_y = longint'(signed'(cfg_data));
                else if (cfg_index == CFG_REGION_X)
                    off_x = longint'(signed'(cfg_data));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (composed_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = composed_q.pop_front();
                    if (rsp.out_pixel_y !== want.out_pixel_y)
                    begin
                        $display("%0t out_pixel_y: expected %0d, actual %0d", $time,
                                 want.out_pixel_y, rsp.out_pixel_y);
                        errors++;
                    end
                    if (rsp.out_pixel_x !== want.out_pixel_x)
                    begin
                        $display("%0t out_pixel_x: expected %0d, actual %0d", $time,
                                 want.out_pixel_x, rsp.out_pixel_x);
                        errors++;
                    end
                    if (rsp.out_flow_x !== want.out_flow_x)
                    begin
                        $display("%0t out_flow_x: expected %0d, actual %0d", $time,
                                 want.out_flow_x, rsp.out_flow_x);
                        errors++;
                    end
                    if (rsp.out_flow_y !== want.out_flow_y)
                    begin
                        $display("%0t out_flow_y: expected %0d, actual %0d", $time,
                                 want.out_flow_y, rsp.out_flow_y);
                        errors++;
                    end
                    if (rsp.out_valid !== want.out_valid)
                    begin
                        $display("%0t out_valid: expected %0d, actual %0d", $time,
                                 want.out_valid, rsp.out_valid);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req.action)
                    composed_q.push_back(compose_pixel(req));
                else
                    flow_store[int'(req.map_row) * RES + int'(req.map_col)] =
                        {req.load_flow_y, req.load_flow_x};
            end
        end
    end
endmodule
`default_nettype wire

### tb/sv/flow_chain_bilinear_compose_tb.sv
// testbench top for the flow chain compose block: reset, clock, stimulus and verdict
// depends on fcbc_pkg, flow_chain_bilinear_compose and flow_chain_bilinear_compose_chk
`default_nettype none
module flow_chain_bilinear_compose_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fcbc_pkg::*;

    localparam int RES   = 1024;
    localparam int LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [11:0]       cfg_data;
    int                errors;
    int                pending;
    int                cycles;
    int                tx_pct;
    int                rx_pct;
    logic              hold_go;
    logic              hold_done;
    int                hold_cnt;
    int                cur_off_y;
    int                cur_off_x;
    bit                loaded [RES*RES];

    flow_chain_bilinear_compose uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    flow_chain_bilinear_compose_chk chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("flow_chain_bilinear_compose verification failed");
            $finish;
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_cnt  <= 400;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_pct);
    end

    function automatic bit cell_ok(int r, int c);
        if (r >= RES || c >= RES)
            return 1'b1;
        return loaded[r * RES + c];
    endfunction

    // would this compose read a map entry never loaded
    function automatic bit reads_unloaded(req_t r);
        longint ty, tx;
        int     row, col;
        if (!r.acc_valid)
            return 1'b0;
        ty = longint'(r.pixel_y) * 256 - longint'(cur_off_y) * 256 - longint'(r.acc_flow_y);
        tx = longint'(r.pixel_x) * 256 - longint'(cur_off_x) * 256 - longint'(r.acc_flow_x);
        if (ty < 0 || tx < 0 || ty > (RES - 1) * 256 || tx > (RES - 1) * 256)
            return 1'b0;
        row = int'(ty >>> 8);
        col = int'(tx >>> 8);
        return !(cell_ok(row, col) && cell_ok(row, col + 1)
                 && cell_ok(row + 1, col) && cell_ok(row + 1, col + 1));
    endfunction

    task automatic push(input req_t r);
        while ($urandom_range(99) < tx_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        if (!r.action)
            loaded[int'(r.map_row) * RES + int'(r.map_col)] = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic load(input int row, input int col, input int fx, input int fy);
        req_t r;
        r             = req_t'({$urandom, $urandom, $urandom, $urandom});
        r.action      = 1'b0;
        r.map_row     = row[9:0];
        r.map_col     = col[9:0];
        r.load_flow_x = fx[FLOW_W-1:0];
        r.load_flow_y = fy[FLOW_W-1:0];
        push(r);
    endtask

    // compose request whose target lands on (ty, tx) in 1/256 units
    task automatic compose_at(input longint ty, input longint tx, input bit vld);
        req_t   r;
        longint ay, ax;
        int     py, px;
        r           = req_t'({$urandom, $urandom, $urandom, $urandom});
        r.action    = 1'b1;
        r.acc_valid = vld;
        for (int k = 0; k < 64; k++)
        begin
            py = $urandom_range(4095);
            ay = longint'(py - cur_off_y) * 256 - ty;
            if (ay >= -524288 && ay <= 524287)
                break;
        end
        for (int k = 0; k < 64; k++)
        begin
            px = $urandom_range(4095);
            ax = longint'(px - cur_off_x) * 256 - tx;
            if (ax >= -524288 && ax <= 524287)
                break;
        end
        r.pixel_y    = py[11:0];
        r.pixel_x    = px[11:0];
        r.acc_flow_y = ay[FLOW_W-1:0];
        r.acc_flow_x = ax[FLOW_W-1:0];
        if (reads_unloaded(r))
            r.acc_valid = 1'b0;
        push(r);
    endtask

    task automatic noise_compose();
        req_t r;
        r        = req_t'({$urandom, $urandom, $urandom, $urandom});
        r.action = 1'b1;
        if (reads_unloaded(r))
            r.acc_valid = 1'b0;
        push(r);
    endtask

    task automatic window_compose();
        longint ty, tx;
        if ($urandom_range(3) == 0)
        begin
            ty = $urandom_range(1023 * 256, 1016 * 256);
            tx = $urandom_range(1023 * 256, 1016 * 256);
        end
        else
        begin
            ty = $urandom_range(7 * 256 - 1, 0);
            tx = $urandom_range(7 * 256 - 1, 0);
        end
        compose_at(ty, tx, $urandom_range(9) != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[11:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_REGION_Y)
            cur_off_y = val;
        else
            cur_off_x = val;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                if ($urandom_range(1))
                    load($urandom_range(7), $urandom_range(7), $urandom, $urandom);
                else
                    load($urandom_range(1023), $urandom_range(1023), $urandom, $urandom);
            end
            else if (pick < 22)
                noise_compose();
            else
                window_compose();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_REGION_Y;
        cfg_data  = '0;
        cycles    = 0;
        tx_pct    = 13;
        rx_pct    = 58;
        hold_go   = 1'b0;
        hold_done = 1'b0;
        hold_cnt  = 0;
        rsp_stall = 1'b0;
        cur_off_y = 0;
        cur_off_x = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(CFG_REGION_Y, 0);
        cfg_write(CFG_REGION_X, 0);

        // fill low corner and far edge windows of the map
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
            begin
                if (r >= 2 && r <= 3 && c >= 2 && c <= 3)
                    load(r, c, 524287, 524287);
                else if (r >= 4 && r <= 5 && c >= 4 && c <= 5)
                    load(r, c, -524288, -524288);
                else
                    load(r, c, $urandom, $urandom);
            end
        for (int r = 1016; r < 1024; r++)
            for (int c = 1016; c < 1024; c++)
                load(r, c, $urandom, $urandom);

        // directed composes
        compose_at(0, 0, 1'b1);
        compose_at(1023 * 256, 1023 * 256, 1'b1);
        compose_at(1023 * 256, 1016 * 256 + 77, 1'b1);
        compose_at(2 * 256, 2 * 256, 1'b1);
        compose_at(2 * 256 + 128, 2 * 256 + 128, 1'b1);
        compose_at(4 * 256, 4 * 256, 1'b1);
        compose_at(4 * 256 + 200, 4 * 256 + 13, 1'b1);
        compose_at(-1, 300, 1'b1);
        compose_at(300, -1, 1'b1);
        compose_at(1023 * 256 + 1, 300, 1'b1);
        compose_at(300, 1023 * 256 + 1, 1'b1);
        compose_at(600, 900, 1'b0);
        compose_at(1 * 256 + 127, 3 * 256 + 128, 1'b1);
        noise_compose();
        noise_compose();
        drain();

        random_phase(580);
        drain();

        cfg_write(CFG_REGION_Y, -2048);
        cfg_write(CFG_REGION_X, 2047);
        tx_pct = 58;
        rx_pct = 13;
        random_phase(580);
        drain();

        cfg_write(CFG_REGION_Y, 2047);
        cfg_write(CFG_REGION_X, -2048);
        tx_pct = 0;
        rx_pct = 0;
        random_phase(100);
        hold_go <= 1'b1;
        random_phase(200);
        drain();

        cfg_write(CFG_REGION_Y, $urandom_range(4095) - 2048);
        cfg_write(CFG_REGION_X, $urandom_range(4095) - 2048);
        random_phase(150);
        drain();

        if (errors == 0)
            $display("flow_chain_bilinear_compose verification clean");
        else
            $display("flow_chain_bilinear_compose verification failed");
        $finish;
    end
endmodule
`default_nettype wire
